// ===== src/tda_pkg.sv =====
// ----------------------------------------------------------------------------
// tda_pkg: shared types and constants of the time-of-day adder
// Opcodes, time fields and the command word passed from front to back.
// ----------------------------------------------------------------------------
package tda_pkg;

  // time units
  localparam int unsigned HOURS_PER_DAY = 24;
  localparam int unsigned MIN_PER_HOUR  = 60;
  localparam int unsigned SEC_PER_MIN   = 60;
  localparam int unsigned MS_PER_SEC    = 1000;

  // opcodes; the two unused codes fall to default arms
  typedef enum logic [2:0] {
    OP_SET      = 3'd0,
    OP_ADD_HOUR = 3'd1,
    OP_ADD_MIN  = 3'd2,
    OP_ADD_SEC  = 3'd3,
    OP_ADD_MS   = 3'd4,
    OP_CMP      = 3'd5
  } op_t;

  typedef logic [2:0] opcode_t;

  // raw operand fields of a beat
  typedef struct packed {
    logic [7:0]  hour;
    logic [7:0]  minute;
    logic [7:0]  second;
    logic [15:0] milli;
  } args_t;

  // a time of day in fields
  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic [9:0] milli;
  } tod_t;

  // classified command handed to the back end
  typedef struct packed {
    opcode_t op;
    logic    set_bad;
    args_t   args;
    tod_t    delta;
  } cmd_t;

endpackage

// ===== src/tda_in_if.sv =====
// ----------------------------------------------------------------------------
// tda_in_if: command channel of the time-of-day adder
// Valid/ready channel carrying one command beat.
// ----------------------------------------------------------------------------
interface tda_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         opcode;
  logic signed [31:0] amount;
  logic [7:0]         arg_hour;
  logic [7:0]         arg_minute;
  logic [7:0]         arg_second;
  logic [15:0]        arg_milli;

  modport source (
    output valid, opcode, amount, arg_hour, arg_minute, arg_second, arg_milli,
    input  ready
  );

  modport sink (
    input  valid, opcode, amount, arg_hour, arg_minute, arg_second, arg_milli,
    output ready
  );
endinterface

// ===== src/tda_out_if.sv =====
// ----------------------------------------------------------------------------
// tda_out_if: result channel of the time-of-day adder
// Valid/ready channel carrying the time after each command.
// ----------------------------------------------------------------------------
interface tda_out_if;
  logic              valid;
  logic              ready;
  logic [4:0]        hour_out;
  logic [5:0]        minute_out;
  logic [5:0]        second_out;
  logic [9:0]        milli_out;
  logic signed [1:0] order;
  logic              range_error;

  modport source (
    output valid, hour_out, minute_out, second_out, milli_out, order, range_error,
    input  ready
  );

  modport sink (
    input  valid, hour_out, minute_out, second_out, milli_out, order, range_error,
    output ready
  );
endinterface

// ===== src/tda_front.sv =====
// ----------------------------------------------------------------------------
// tda_front: command front end
// Takes command beats, range-checks set operands and turns a signed add
// amount into a non-negative offset split into hour/minute/second/milli
// fields, through a ten-stage reciprocal-multiply pipeline.
// ----------------------------------------------------------------------------
module tda_front (
  input  logic          clk,
  input  logic          rst_n,
  tda_in_if.sink        in_bus,
  input  logic          q_full,
  output logic          push,
  output tda_pkg::cmd_t push_cmd
);
  import tda_pkg::*;

  localparam int unsigned STAGES = 10;
  localparam int unsigned LAST   = STAGES - 1;
  localparam int unsigned MOD_W  = 28;
  localparam int unsigned DAY_W  = 27;

  // pipeline stage roles
  localparam int unsigned ST_IN    = 0;
  localparam int unsigned ST_RMUL  = 1;
  localparam int unsigned ST_RQN   = 2;
  localparam int unsigned ST_RFIX  = 3;
  localparam int unsigned ST_MSMUL = 4;
  localparam int unsigned ST_MSFIX = 5;
  localparam int unsigned ST_SMUL  = 6;
  localparam int unsigned ST_SFIX  = 7;
  localparam int unsigned ST_MMUL  = 8;
  localparam int unsigned ST_MFIX  = 9;

  // day length in each unit
  localparam logic [DAY_W-1:0] N_HOUR = DAY_W'(HOURS_PER_DAY);
  localparam logic [DAY_W-1:0] N_MIN  = DAY_W'(HOURS_PER_DAY * MIN_PER_HOUR);
  localparam logic [DAY_W-1:0] N_SEC  = DAY_W'(HOURS_PER_DAY * MIN_PER_HOUR * SEC_PER_MIN);
  localparam logic [DAY_W-1:0] N_MS   =
    DAY_W'(HOURS_PER_DAY * MIN_PER_HOUR * SEC_PER_MIN * MS_PER_SEC);

  // floor(2^32 / n) and 2^31 mod n for the offset-binary reduction
  localparam logic [MOD_W-1:0] RCP_HOUR = MOD_W'((64'd1 << 32) / 64'(N_HOUR));
  localparam logic [MOD_W-1:0] RCP_MIN  = MOD_W'((64'd1 << 32) / 64'(N_MIN));
  localparam logic [MOD_W-1:0] RCP_SEC  = MOD_W'((64'd1 << 32) / 64'(N_SEC));
  localparam logic [MOD_W-1:0] RCP_MS   = MOD_W'((64'd1 << 32) / 64'(N_MS));
  localparam logic [MOD_W-1:0] OFS_HOUR = MOD_W'((64'd1 << 31) % 64'(N_HOUR));
  localparam logic [MOD_W-1:0] OFS_MIN  = MOD_W'((64'd1 << 31) % 64'(N_MIN));
  localparam logic [MOD_W-1:0] OFS_SEC  = MOD_W'((64'd1 << 31) % 64'(N_SEC));
  localparam logic [MOD_W-1:0] OFS_MS   = MOD_W'((64'd1 << 31) % 64'(N_MS));

  // reciprocals for splitting the offset into fields
  localparam logic [17:0] RCP_DIV_MS  = 18'((64'd1 << 27) / 64'(MS_PER_SEC));
  localparam logic [11:0] RCP_DIV_SEC = 12'((64'd1 << 17) / 64'(SEC_PER_MIN));
  localparam logic [5:0]  RCP_DIV_MIN = 6'((64'd1 << 11) / 64'(MIN_PER_HOUR));

  typedef struct packed {
    opcode_t          op;
    logic             bad;
    args_t            args;
    logic [31:0]      acc;
    logic [MOD_W-1:0] aux;
    tod_t             delta;
  } fst_t;

  fst_t             fs_r   [STAGES];
  fst_t             fs_nxt [STAGES];
  logic [LAST:0]    v_r;
  logic             adv;

  function automatic logic [MOD_W-1:0] rcp_of(input opcode_t op);
    case (op)
      OP_ADD_MIN: rcp_of = RCP_MIN;
      OP_ADD_SEC: rcp_of = RCP_SEC;
      OP_ADD_MS:  rcp_of = RCP_MS;
      default:    rcp_of = RCP_HOUR;
    endcase
  endfunction

  function automatic logic [DAY_W-1:0] n_of(input opcode_t op);
    case (op)
      OP_ADD_MIN: n_of = N_MIN;
      OP_ADD_SEC: n_of = N_SEC;
      OP_ADD_MS:  n_of = N_MS;
      default:    n_of = N_HOUR;
    endcase
  endfunction

  function automatic logic [MOD_W-1:0] ofs_of(input opcode_t op);
    case (op)
      OP_ADD_MIN: ofs_of = OFS_MIN;
      OP_ADD_SEC: ofs_of = OFS_SEC;
      OP_ADD_MS:  ofs_of = OFS_MS;
      default:    ofs_of = OFS_HOUR;
    endcase
  endfunction

  // whole pipe moves together; it freezes only when the last beat cannot leave
  assign adv          = !v_r[LAST] || !q_full;
  assign in_bus.ready = adv;
  assign push         = v_r[LAST] && !q_full;

  assign push_cmd.op      = fs_r[LAST].op;
  assign push_cmd.set_bad = fs_r[LAST].bad;
  assign push_cmd.args    = fs_r[LAST].args;
  assign push_cmd.delta   = fs_r[LAST].delta;

  // stage logic
  always_comb begin
    logic [59:0]       rprod;
    logic [54:0]       qn;
    logic [MOD_W-1:0]  r;
    logic signed [28:0] rr;
    logic signed [28:0] n_s;
    logic [44:0]       aprod;
    logic [10:0]       ar;
    logic [17:0]       aq;
    logic [28:0]       bprod;
    logic [6:0]        br;
    logic [10:0]       bq;
    logic [16:0]       cprod;
    logic [6:0]        cr;
    logic [4:0]        cq;

    // capture; amount goes to offset binary
    fs_nxt[ST_IN].op          = in_bus.opcode;
    fs_nxt[ST_IN].args.hour   = in_bus.arg_hour;
    fs_nxt[ST_IN].args.minute = in_bus.arg_minute;
    fs_nxt[ST_IN].args.second = in_bus.arg_second;
    fs_nxt[ST_IN].args.milli  = in_bus.arg_milli;
    fs_nxt[ST_IN].bad = (in_bus.opcode == OP_SET) &&
                        ((in_bus.arg_hour   >= 8'(HOURS_PER_DAY)) ||
                         (in_bus.arg_minute >= 8'(MIN_PER_HOUR))  ||
                         (in_bus.arg_second >= 8'(SEC_PER_MIN))   ||
                         (in_bus.arg_milli  >= 16'(MS_PER_SEC)));
    fs_nxt[ST_IN].acc   = {~in_bus.amount[31], in_bus.amount[30:0]};
    fs_nxt[ST_IN].aux   = '0;
    fs_nxt[ST_IN].delta = '0;

    // quotient estimate of the offset-binary amount by the day length
    fs_nxt[ST_RMUL]     = fs_r[ST_IN];
    rprod               = 60'(fs_r[ST_IN].acc) * 60'(rcp_of(fs_r[ST_IN].op));
    fs_nxt[ST_RMUL].aux = fs_r[ST_IN].acc[MOD_W-1:0];
    fs_nxt[ST_RMUL].acc = 32'(rprod[59:32]);

    // estimate times day length, low bits only
    fs_nxt[ST_RQN]     = fs_r[ST_RMUL];
    qn                 = 55'(fs_r[ST_RMUL].acc[MOD_W-1:0]) * 55'(n_of(fs_r[ST_RMUL].op));
    fs_nxt[ST_RQN].acc = 32'(qn[MOD_W-1:0]);

    // remainder, undo the offset, fold into one day
    fs_nxt[ST_RFIX] = fs_r[ST_RQN];
    r   = fs_r[ST_RQN].aux - fs_r[ST_RQN].acc[MOD_W-1:0];
    n_s = $signed({2'b00, n_of(fs_r[ST_RQN].op)});
    rr  = $signed({1'b0, r}) - $signed({1'b0, ofs_of(fs_r[ST_RQN].op)});
    if (rr < 0) begin
      rr = rr + n_s;
    end else if (rr >= n_s) begin
      rr = rr - n_s;
    end
    fs_nxt[ST_RFIX].acc = 32'(rr[DAY_W-1:0]);

    // milliseconds: quotient estimate
    fs_nxt[ST_MSMUL]     = fs_r[ST_RFIX];
    fs_nxt[ST_MSMUL].aux = fs_r[ST_RFIX].acc[MOD_W-1:0];
    aprod                = 45'(fs_r[ST_RFIX].acc[DAY_W-1:0]) * 45'(RCP_DIV_MS);
    if (fs_r[ST_RFIX].op == OP_ADD_MS) begin
      fs_nxt[ST_MSMUL].acc = 32'(aprod[44:27]);
    end

    // milliseconds: remainder and correction
    fs_nxt[ST_MSFIX] = fs_r[ST_MSMUL];
    ar = fs_r[ST_MSMUL].aux[10:0] - 11'(fs_r[ST_MSMUL].acc[17:0] * 18'(MS_PER_SEC));
    aq = fs_r[ST_MSMUL].acc[17:0];
    if (ar >= 11'(MS_PER_SEC)) begin
      ar = ar - 11'(MS_PER_SEC);
      aq = aq + 18'd1;
    end
    if (fs_r[ST_MSMUL].op == OP_ADD_MS) begin
      fs_nxt[ST_MSFIX].delta.milli = ar[9:0];
      fs_nxt[ST_MSFIX].acc         = 32'(aq);
    end

    // seconds: quotient estimate
    fs_nxt[ST_SMUL]     = fs_r[ST_MSFIX];
    fs_nxt[ST_SMUL].aux = fs_r[ST_MSFIX].acc[MOD_W-1:0];
    bprod               = 29'(fs_r[ST_MSFIX].acc[16:0]) * 29'(RCP_DIV_SEC);
    if ((fs_r[ST_MSFIX].op == OP_ADD_MS) || (fs_r[ST_MSFIX].op == OP_ADD_SEC)) begin
      fs_nxt[ST_SMUL].acc = 32'(bprod[28:17]);
    end

    // seconds: remainder and correction
    fs_nxt[ST_SFIX] = fs_r[ST_SMUL];
    br = fs_r[ST_SMUL].aux[6:0] - 7'(fs_r[ST_SMUL].acc[11:0] * 12'(SEC_PER_MIN));
    bq = fs_r[ST_SMUL].acc[10:0];
    if (br >= 7'(SEC_PER_MIN)) begin
      br = br - 7'(SEC_PER_MIN);
      bq = bq + 11'd1;
    end
    if ((fs_r[ST_SMUL].op == OP_ADD_MS) || (fs_r[ST_SMUL].op == OP_ADD_SEC)) begin
      fs_nxt[ST_SFIX].delta.second = br[5:0];
      fs_nxt[ST_SFIX].acc          = 32'(bq);
    end

    // minutes: quotient estimate
    fs_nxt[ST_MMUL]     = fs_r[ST_SFIX];
    fs_nxt[ST_MMUL].aux = fs_r[ST_SFIX].acc[MOD_W-1:0];
    cprod               = 17'(fs_r[ST_SFIX].acc[10:0]) * 17'(RCP_DIV_MIN);
    if ((fs_r[ST_SFIX].op == OP_ADD_MS) || (fs_r[ST_SFIX].op == OP_ADD_SEC) ||
        (fs_r[ST_SFIX].op == OP_ADD_MIN)) begin
      fs_nxt[ST_MMUL].acc = 32'(cprod[16:11]);
    end

    // minutes: remainder and correction; what is left is hours
    fs_nxt[ST_MFIX] = fs_r[ST_MMUL];
    cr = fs_r[ST_MMUL].aux[6:0] - 7'(fs_r[ST_MMUL].acc[6:0] * 7'(MIN_PER_HOUR));
    cq = fs_r[ST_MMUL].acc[4:0];
    if (cr >= 7'(MIN_PER_HOUR)) begin
      cr = cr - 7'(MIN_PER_HOUR);
      cq = cq + 5'd1;
    end
    if ((fs_r[ST_MMUL].op == OP_ADD_MS) || (fs_r[ST_MMUL].op == OP_ADD_SEC) ||
        (fs_r[ST_MMUL].op == OP_ADD_MIN)) begin
      fs_nxt[ST_MFIX].delta.minute = cr[5:0];
      fs_nxt[ST_MFIX].delta.hour   = cq;
    end else begin
      fs_nxt[ST_MFIX].delta.hour   = fs_r[ST_MMUL].acc[4:0];
    end
  end

  // stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[LAST-1:0], in_bus.valid};
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < STAGES; i++) begin
        fs_r[i] <= fs_nxt[i];
      end
    end
  end

endmodule

// ===== src/tda_fifo.sv =====
// ----------------------------------------------------------------------------
// tda_fifo: command queue between front end and back end
// Small register queue with the head shown combinationally.
// ----------------------------------------------------------------------------
module tda_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  tda_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output tda_pkg::cmd_t head
);
  import tda_pkg::*;

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  cmd_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full       = (count_r == CNT_W'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head       = mem_r[rd_ptr_r];

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ===== src/tda_exec.sv =====
// ----------------------------------------------------------------------------
// tda_exec: command back end
// Holds the time of day, applies set/add/compare one command per cycle while the
// result channel is not stalled, and drives that channel from the state and two flag registers.
// ----------------------------------------------------------------------------
module tda_exec (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          head_valid,
  input  tda_pkg::cmd_t head,
  output logic          pop,
  tda_out_if.source     out_bus
);
  import tda_pkg::*;

  localparam logic signed [1:0] ORD_EARLIER = -2'sd1;
  localparam logic signed [1:0] ORD_SAME    = 2'sd0;
  localparam logic signed [1:0] ORD_LATER   = 2'sd1;

  tod_t              tod_r, tod_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic signed [1:0] order_r, order_nxt;
  logic              err_r, err_nxt;

  // take the next command when the result slot is free or being emptied
  assign pop = head_valid && (!out_valid_r || out_bus.ready);

  assign out_bus.valid       = out_valid_r;
  assign out_bus.hour_out    = tod_r.hour;
  assign out_bus.minute_out  = tod_r.minute;
  assign out_bus.second_out  = tod_r.second;
  assign out_bus.milli_out   = tod_r.milli;
  assign out_bus.order       = order_r;
  assign out_bus.range_error = err_r;

  // command execution
  always_comb begin
    logic [10:0] ms_sum;
    logic [6:0]  s_sum;
    logic [6:0]  m_sum;
    logic [5:0]  h_sum;
    logic        c_ms;
    logic        c_s;
    logic        c_m;

    tod_nxt       = tod_r;
    order_nxt     = order_r;
    err_nxt       = err_r;
    out_valid_nxt = out_valid_r && !out_bus.ready;

    // field-wise add with carries; unused offset fields are zero
    ms_sum = 11'(tod_r.milli) + 11'(head.delta.milli);
    c_ms   = (ms_sum >= 11'(MS_PER_SEC));
    if (c_ms) begin
      ms_sum = ms_sum - 11'(MS_PER_SEC);
    end
    s_sum = 7'(tod_r.second) + 7'(head.delta.second) + 7'(c_ms);
    c_s   = (s_sum >= 7'(SEC_PER_MIN));
    if (c_s) begin
      s_sum = s_sum - 7'(SEC_PER_MIN);
    end
    m_sum = 7'(tod_r.minute) + 7'(head.delta.minute) + 7'(c_s);
    c_m   = (m_sum >= 7'(MIN_PER_HOUR));
    if (c_m) begin
      m_sum = m_sum - 7'(MIN_PER_HOUR);
    end
    h_sum = 6'(tod_r.hour) + 6'(head.delta.hour) + 6'(c_m);
    if (h_sum >= 6'(HOURS_PER_DAY)) begin
      h_sum = h_sum - 6'(HOURS_PER_DAY);
    end

    if (pop) begin
      out_valid_nxt = 1'b1;
      order_nxt     = ORD_SAME;
      err_nxt       = 1'b0;
      case (head.op)
        OP_SET: begin
          if (head.set_bad) begin
            err_nxt = 1'b1;
          end else begin
            tod_nxt.hour   = head.args.hour[4:0];
            tod_nxt.minute = head.args.minute[5:0];
            tod_nxt.second = head.args.second[5:0];
            tod_nxt.milli  = head.args.milli[9:0];
          end
        end
        OP_ADD_HOUR, OP_ADD_MIN, OP_ADD_SEC, OP_ADD_MS: begin
          tod_nxt.hour   = h_sum[4:0];
          tod_nxt.minute = m_sum[5:0];
          tod_nxt.second = s_sum[5:0];
          tod_nxt.milli  = ms_sum[9:0];
        end
        OP_CMP: begin
          // hour first, millisecond last
          if (8'(tod_r.hour) != head.args.hour) begin
            order_nxt = (8'(tod_r.hour) < head.args.hour) ? ORD_EARLIER : ORD_LATER;
          end else if (8'(tod_r.minute) != head.args.minute) begin
            order_nxt = (8'(tod_r.minute) < head.args.minute) ? ORD_EARLIER : ORD_LATER;
          end else if (8'(tod_r.second) != head.args.second) begin
            order_nxt = (8'(tod_r.second) < head.args.second) ? ORD_EARLIER : ORD_LATER;
          end else if (16'(tod_r.milli) != head.args.milli) begin
            order_nxt = (16'(tod_r.milli) < head.args.milli) ? ORD_EARLIER : ORD_LATER;
          end
        end
        default: begin
          order_nxt = ORD_SAME;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tod_r       <= '0;
      out_valid_r <= 1'b0;
      order_r     <= ORD_SAME;
      err_r       <= 1'b0;
    end else begin
      tod_r       <= tod_nxt;
      out_valid_r <= out_valid_nxt;
      order_r     <= order_nxt;
      err_r       <= err_nxt;
    end
  end

endmodule

// ===== src/time_of_day_adder_core.sv =====
// ----------------------------------------------------------------------------
// time_of_day_adder_core: time-of-day register with set, add and compare
// Front end reduces add amounts into field offsets, a queue decouples it
// from the back end, which updates the stored time and returns it.
// ----------------------------------------------------------------------------
//   channel   | dir | handshake            | beat contents
//   ----------+-----+----------------------+----------------------------------
//   in_bus    | in  | valid/ready          | opcode, amount, arg_* operands
//   out_bus   | out | valid/ready          | time fields, order, range_error
//
// One command per cycle sustained while out_bus is not stalled; a result passes
// through the ten-stage reciprocal pipeline in the front end, the queue and the
// registered carry add on the stored time in the back end.
// Reset clears the stored time to 00:00:00.000 and empties pipe and queue.
// A stalled result holds; the queue absorbs QUEUE_DEPTH commands, after that
// the front end freezes and in_bus.ready drops.
// ----------------------------------------------------------------------------
module time_of_day_adder_core #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  tda_in_if.sink    in_bus,
  tda_out_if.source out_bus
);
  import tda_pkg::*;

  logic q_push;
  cmd_t q_push_cmd;
  logic q_full;
  logic q_pop;
  logic q_head_valid;
  cmd_t q_head;

  // classify and reduce commands
  tda_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_bus   (in_bus),
    .q_full   (q_full),
    .push     (q_push),
    .push_cmd (q_push_cmd)
  );

  // decoupling queue
  tda_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (q_push_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head       (q_head)
  );

  // execute against the stored time
  tda_exec u_exec (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_head_valid),
    .head       (q_head),
    .pop        (q_pop),
    .out_bus    (out_bus)
  );

endmodule

// ===== dv/tda_time_monitor.sv =====
// ----------------------------------------------------------------------------
// tda_time_monitor: result predictor and comparator for the time-of-day adder
// Watches both channels, keeps a shadow copy of the stored time, works out
// the time, order and range flag each command beat should return, and
// compares every result beat against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module tda_time_monitor (
  input  logic        clk,
  input  logic        rst_n,
  tda_in_if           in_bus,
  tda_out_if          out_bus,
  output int unsigned fail_count,
  output int unsigned pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import tda_pkg::*;

  localparam longint MS_PER_MINUTE = 60_000;
  localparam longint MS_PER_HOUR   = 3_600_000;
  localparam longint MS_PER_DAY    = 86_400_000;

  localparam logic signed [1:0] ORD_EARLIER = -2'sd1;
  localparam logic signed [1:0] ORD_EQUAL   = 2'sd0;
  localparam logic signed [1:0] ORD_LATER   = 2'sd1;

  // what one command beat should return
  typedef struct packed {
    tod_t              tod;
    logic signed [1:0] order;
    logic              range_error;
  } tod_result_t;

  tod_t          shadow_time = '0;
  tod_result_t   predicted_results[$];
  tod_result_t   oldest;
  int unsigned   mismatches = 0;
  int unsigned   outstanding = 0;
  int unsigned   result_beats = 0;

  assign fail_count = mismatches;
  assign pending    = outstanding;

  // field-by-field ordering, hour first, operands taken as plain unsigned
  function automatic logic signed [1:0] order_against(input tod_t cur, input args_t a);
    if (cur.hour != a.hour) return (cur.hour < a.hour) ? ORD_EARLIER : ORD_LATER;
    if (cur.minute != a.minute) return (cur.minute < a.minute) ? ORD_EARLIER : ORD_LATER;
    if (cur.second != a.second) return (cur.second < a.second) ? ORD_EARLIER : ORD_LATER;
    if (cur.milli != a.milli) return (cur.milli < a.milli) ? ORD_EARLIER : ORD_LATER;
    return ORD_EQUAL;
  endfunction

  // time after one command, plus compare and range flags
  function automatic tod_result_t next_time_of_day(input tod_t cur, input logic [2:0] op,
                                                   input logic signed [31:0] amount,
                                                   input args_t a);
    tod_result_t r;
    longint      unit_ms;
    longint      shift_ms;
    longint      day_ms;
    r.tod         = cur;
    r.order       = ORD_EQUAL;
    r.range_error = 1'b0;
    unit_ms       = 0;
    case (op)
      OP_SET: begin
        if (a.hour >= HOURS_PER_DAY || a.minute >= MIN_PER_HOUR ||
            a.second >= SEC_PER_MIN || a.milli >= MS_PER_SEC) begin
          r.range_error = 1'b1;
        end else begin
          r.tod.hour   = a.hour[4:0];
          r.tod.minute = a.minute[5:0];
          r.tod.second = a.second[5:0];
          r.tod.milli  = a.milli[9:0];
        end
      end
      OP_ADD_HOUR: unit_ms = MS_PER_HOUR;
      OP_ADD_MIN:  unit_ms = MS_PER_MINUTE;
      OP_ADD_SEC:  unit_ms = MS_PER_SEC;
      OP_ADD_MS:   unit_ms = 1;
      OP_CMP:      r.order = order_against(cur, a);
      default: ;
    endcase
    // adds work on the whole day in ms, floor modulo one day
    if (unit_ms != 0) begin
      shift_ms = (longint'(amount) * unit_ms) % MS_PER_DAY;
      if (shift_ms < 0) shift_ms += MS_PER_DAY;
      day_ms = longint'(cur.hour) * MS_PER_HOUR + longint'(cur.minute) * MS_PER_MINUTE +
               longint'(cur.second) * MS_PER_SEC + longint'(cur.milli);
      day_ms = (day_ms + shift_ms) % MS_PER_DAY;
      r.tod.hour   = 5'(day_ms / MS_PER_HOUR);
      r.tod.minute = 6'((day_ms % MS_PER_HOUR) / MS_PER_MINUTE);
      r.tod.second = 6'((day_ms % MS_PER_MINUTE) / MS_PER_SEC);
      r.tod.milli  = 10'(day_ms % MS_PER_SEC);
    end
    return r;
  endfunction

  task automatic report(input string what, input int got, input int want);
    mismatches++;
    $display("[%0t] result beat %0d: %s got %0d want %0d",
             $realtime, result_beats, what, got, want);
  endtask

  // result side first, then record the command beat taken at this edge
  always @(posedge clk) begin
    if (!rst_n) begin
      shadow_time = '0;
      predicted_results.delete();
      outstanding <= 0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        result_beats++;
        if (predicted_results.size() == 0) begin
          report("beat with nothing outstanding, hour", int'(out_bus.hour_out), -1);
        end else begin
          oldest = predicted_results.pop_front();
          if (out_bus.hour_out !== oldest.tod.hour)
            report("hour", int'(out_bus.hour_out), int'(oldest.tod.hour));
          if (out_bus.minute_out !== oldest.tod.minute)
            report("minute", int'(out_bus.minute_out), int'(oldest.tod.minute));
          if (out_bus.second_out !== oldest.tod.second)
            report("second", int'(out_bus.second_out), int'(oldest.tod.second));
          if (out_bus.milli_out !== oldest.tod.milli)
            report("milli", int'(out_bus.milli_out), int'(oldest.tod.milli));
          if (out_bus.order !== oldest.order)
            report("order", int'(out_bus.order), int'(oldest.order));
          if (out_bus.range_error !== oldest.range_error)
            report("range_error", int'(out_bus.range_error), int'(oldest.range_error));
        end
      end
      if (in_bus.valid && in_bus.ready) begin
        predicted_results.push_back(next_time_of_day(shadow_time, in_bus.opcode,
          in_bus.amount, '{in_bus.arg_hour, in_bus.arg_minute, in_bus.arg_second,
          in_bus.arg_milli}));
        shadow_time = predicted_results[$].tod;
      end
      outstanding <= predicted_results.size();
    end
  end

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: testbench top of the time-of-day adder
// Drives directed and random set, add and compare commands with random
// gaps and result stalls; a monitor beside the block predicts and checks
// every result, and this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import tda_pkg::*;

  localparam int      CLK_PERIOD   = 8;
  localparam int      RANDOM_ITEMS = 1800;
  localparam int      QUIET_TAIL   = 200;
  localparam int      DRAIN_EVERY  = 400;
  localparam opcode_t OP_SPARE_LO  = 3'd6;
  localparam opcode_t OP_SPARE_HI  = 3'd7;

  localparam logic signed [31:0] AMOUNT_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] AMOUNT_MIN = 32'sh8000_0000;

  // one command beat
  typedef struct packed {
    opcode_t            op;
    logic signed [31:0] amount;
    args_t              args;
  } tod_cmd_t;

  logic        clk;
  logic        rst_n;
  bit          quiet = 1'b0;
  int          gap_pct = 0;
  int unsigned failures;
  int unsigned outstanding;

  tda_in_if  in_bus ();
  tda_out_if out_bus ();

  time_of_day_adder_core dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

  tda_time_monitor u_monitor (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_bus     (in_bus),
    .out_bus    (out_bus),
    .fail_count (failures),
    .pending    (outstanding)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // run limit
  initial begin
    #8ms;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic tod_cmd_t make_cmd(input opcode_t op, input logic signed [31:0] amount,
                                        input logic [7:0] h, input logic [7:0] m,
                                        input logic [7:0] s, input logic [15:0] ms);
    tod_cmd_t c;
    c.op     = op;
    c.amount = amount;
    c.args   = '{h, m, s, ms};
    return c;
  endfunction

  // any legal time of day, with a bias toward hour and millisecond edges
  function automatic args_t rand_time();
    args_t t;
    t.hour   = $urandom_range(0, 3) == 0 ? 8'($urandom_range(0, 1) * 23) : 8'($urandom_range(0, 23));
    t.minute = 8'($urandom_range(0, 59));
    t.second = 8'($urandom_range(0, 59));
    t.milli  = $urandom_range(0, 3) == 0 ? 16'($urandom_range(0, 1) * 999)
                                         : 16'($urandom_range(0, 999));
    return t;
  endfunction

  function automatic logic signed [31:0] rand_amount();
    int                 sel;
    logic signed [31:0] v;
    sel = $urandom_range(0, 4);
    case (sel)
      0: v = $urandom_range(0, 120);
      1: v = $urandom_range(0, 200_000);
      2: v = $urandom;
      3: v = $urandom_range(0, 1) ? AMOUNT_MAX : AMOUNT_MIN;
      default: v = $urandom_range(0, 2);
    endcase
    if (sel != 2 && $urandom_range(0, 1)) v = -v;
    return v;
  endfunction

  task automatic send_cmd(input tod_cmd_t c);
    in_bus.valid      <= 1'b1;
    in_bus.opcode     <= c.op;
    in_bus.amount     <= c.amount;
    in_bus.arg_hour   <= c.args.hour;
    in_bus.arg_minute <= c.args.minute;
    in_bus.arg_second <= c.args.second;
    in_bus.arg_milli  <= c.args.milli;
    do @(posedge clk); while (!in_bus.ready);
  endtask

  task automatic hold_off(input int cycles);
    in_bus.valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // sender random gap, then the beat
  task automatic issue(input tod_cmd_t c);
    if (!quiet && $urandom_range(0, 99) < gap_pct) hold_off($urandom_range(1, 19));
    send_cmd(c);
  endtask

  // hold the sender until every result is back
  task automatic drain();
    in_bus.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // result side stalls in bursts, none in the quiet tail
  initial begin
    out_bus.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (quiet || $urandom_range(0, 3) != 0) begin
        out_bus.ready <= 1'b1;
        repeat ($urandom_range(1, 40)) @(posedge clk);
      end else begin
        out_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
    end
  end

  // stimulus and verdict
  initial begin
    tod_cmd_t c;
    args_t    t;
    int       sent;
    int       kind;
    int       next_drain;
    int       waits;
    rst_n             <= 1'b0;
    in_bus.valid      <= 1'b0;
    in_bus.opcode     <= OP_SET;
    in_bus.amount     <= '0;
    in_bus.arg_hour   <= '0;
    in_bus.arg_minute <= '0;
    in_bus.arg_second <= '0;
    in_bus.arg_milli  <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: field extremes, wraps both ways, bad sets, compares, spare codes
    gap_pct = 30;
    issue(make_cmd(OP_SET, 0, 23, 59, 59, 999));
    issue(make_cmd(OP_CMP, 0, 23, 59, 59, 999));
    issue(make_cmd(OP_ADD_MS, 1, 0, 0, 0, 0));
    issue(make_cmd(OP_ADD_MS, -1, 0, 0, 0, 0));
    issue(make_cmd(OP_SET, AMOUNT_MIN, 0, 0, 0, 0));
    issue(make_cmd(OP_SET, 0, 24, 0, 0, 0));
    issue(make_cmd(OP_SET, 0, 0, 60, 0, 0));
    issue(make_cmd(OP_SET, 0, 0, 0, 60, 0));
    issue(make_cmd(OP_SET, 0, 0, 0, 0, 1000));
    issue(make_cmd(OP_SET, AMOUNT_MAX, 8'hff, 8'hff, 8'hff, 16'hffff));
    issue(make_cmd(OP_ADD_HOUR, 0, 8'hff, 8'hff, 8'hff, 16'hffff));
    issue(make_cmd(OP_ADD_HOUR, AMOUNT_MAX, 0, 0, 0, 0));
    issue(make_cmd(OP_ADD_HOUR, AMOUNT_MIN, 0, 0, 0, 0));
    issue(make_cmd(OP_ADD_MIN, -1, 0, 0, 0, 0));
    issue(make_cmd(OP_ADD_SEC, AMOUNT_MAX, 0, 0, 0, 0));
    issue(make_cmd(OP_ADD_MS, AMOUNT_MIN, 0, 0, 0, 0));
    issue(make_cmd(OP_ADD_MS, 1000, 0, 0, 0, 0));
    issue(make_cmd(OP_CMP, 0, 0, 0, 0, 0));
    issue(make_cmd(OP_CMP, 0, 8'hff, 8'hff, 8'hff, 16'hffff));
    issue(make_cmd(OP_SET, 0, 12, 30, 30, 500));
    issue(make_cmd(OP_CMP, 0, 12, 30, 30, 499));
    issue(make_cmd(OP_CMP, 0, 12, 30, 30, 501));
    issue(make_cmd(OP_SPARE_LO, $urandom, 8'($urandom), 8'($urandom), 8'($urandom), 16'($urandom)));
    issue(make_cmd(OP_SPARE_HI, $urandom, 8'($urandom), 8'($urandom), 8'($urandom), 16'($urandom)));
    issue(make_cmd(OP_ADD_MIN, 1440, 0, 0, 0, 0));
    drain();

    // random commands, gap rate changing every 150 beats
    sent       = 0;
    next_drain = DRAIN_EVERY;
    while (sent < RANDOM_ITEMS) begin
      quiet = (sent >= RANDOM_ITEMS - QUIET_TAIL);
      case ((sent / 150) % 3)
        0:       gap_pct = 0;
        1:       gap_pct = 12;
        default: gap_pct = 50;
      endcase
      if (sent >= next_drain) begin
        drain();
        next_drain += DRAIN_EVERY;
      end
      c.op     = OP_SET;
      c.amount = $urandom;
      c.args   = {$urandom, 8'($urandom)};
      kind     = $urandom_range(0, 99);
      if (kind < 20) begin
        // set a time, then compare against it with at most one field nudged
        t      = rand_time();
        c.args = t;
        issue(c);
        c.op     = OP_CMP;
        c.amount = $urandom;
        case ($urandom_range(0, 4))
          0:       t.hour   = t.hour + 8'($urandom_range(0, 2)) - 8'd1;
          1:       t.minute = t.minute + 8'($urandom_range(0, 2)) - 8'd1;
          2:       t.second = t.second + 8'($urandom_range(0, 2)) - 8'd1;
          3:       t.milli  = t.milli + 16'($urandom_range(0, 2)) - 16'd1;
          default: ;
        endcase
        c.args = t;
        sent++;
      end else if (kind < 35) begin
        c.args = rand_time();
      end else if (kind < 42) begin
        // full-range operands, mostly out of range
      end else if (kind < 82) begin
        c.op     = opcode_t'($urandom_range(OP_ADD_HOUR, OP_ADD_MS));
        c.amount = rand_amount();
      end else if (kind < 94) begin
        c.op = OP_CMP;
        if ($urandom_range(0, 1)) c.args = rand_time();
      end else begin
        c.op = $urandom_range(0, 1) ? OP_SPARE_LO : OP_SPARE_HI;
      end
      issue(c);
      sent++;
    end

    // let the last results through
    quiet = 1'b1;
    in_bus.valid <= 1'b0;
    waits = 0;
    do begin
      @(posedge clk);
      waits++;
    end while (outstanding != 0 && waits < 5000);
    repeat (20) @(posedge clk);
    if (failures == 0 && outstanding == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
